[rtl/ptc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure/temperature compensation unit.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int RAW_W     = 20;
  localparam int TEMP_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int DVS_W     = 31;
  localparam int REM_W     = DVS_W + 1;
  localparam int DIV_N     = WIDE_W;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 64;

  localparam logic signed [33:0] T_OFFSET = 34'sd128000;
  localparam logic [20:0]        P_FULL   = 21'd1048576;
  localparam logic [11:0]        P_SCALE  = 12'd3125;
  localparam logic [63:0]        BIAS47   = 64'h0000_8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP  = 4'd0,
    REG_PLOW  = 4'd1,
    REG_PHIGH = 4'd2,
    REG_PNINE = 4'd3
  } cfg_reg_t;

  // Side information that travels with an item through the divider.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] fine;
    logic                     dz;
    logic                     neg;
  } tag_t;

endpackage

[rtl/ptc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_in_if
// Input channel: one pair of raw converter readings per item.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

[rtl/ptc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_out_if
// Result channel: compensated temperature and pressure per item.
// ----------------------------------------------------------------------------
interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic [31:0]        pressure_q24_8;
  logic               divide_by_zero;

  modport source (output valid, output temperature_centi, output fine_temperature,
                  output pressure_q24_8, output divide_by_zero, input ready);
  modport sink   (input valid, input temperature_centi, input fine_temperature,
                  input pressure_q24_8, input divide_by_zero, output ready);
endinterface

[rtl/ptc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ptc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider, one quotient bit per stage, unsigned
// magnitudes. A tag rides along with every item.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [ptc_pkg::WIDE_W-1:0]    num,
  input  logic [ptc_pkg::DVS_W-1:0]     dvs,
  input  ptc_pkg::tag_t                 in_tag,
  output logic                          out_vld,
  output logic [ptc_pkg::WIDE_W-1:0]    quo,
  output ptc_pkg::tag_t                 out_tag
);
  import ptc_pkg::*;

  logic [DIV_N-1:0] vld;
  logic [REM_W-1:0] rem [DIV_N];
  logic [WIDE_W-1:0] qd [DIV_N];
  logic [DVS_W-1:0] dv [DIV_N];
  tag_t             tg [DIV_N];

  for (genvar j = 0; j < DIV_N; j++) begin : g_st
    logic [REM_W-1:0]  r_in;
    logic [WIDE_W-1:0] q_in;
    logic [DVS_W-1:0]  d_in;
    tag_t              t_in;
    logic              v_in;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;

    if (j == 0) begin : g_first
      assign r_in = '0;
      assign q_in = num;
      assign d_in = dvs;
      assign t_in = in_tag;
      assign v_in = in_vld;
    end else begin : g_next
      assign r_in = rem[j-1];
      assign q_in = qd[j-1];
      assign d_in = dv[j-1];
      assign t_in = tg[j-1];
      assign v_in = vld[j-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_in[REM_W-2:0], q_in[WIDE_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= diff[REM_W] ? trial : diff[REM_W-1:0];
        qd[j]  <= {q_in[WIDE_W-2:0], ~diff[REM_W]};
        dv[j]  <= d_in;
        tg[j]  <= t_in;
      end
    end
  end

  assign out_vld = vld[DIV_N-1];
  assign quo     = qd[DIV_N-1];
  assign out_tag = tg[DIV_N-1];

endmodule

[rtl/pressure_temperature_compensation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Calibrated temperature and pressure from raw 20-bit converter readings.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one item = raw_temperature and raw_pressure readings.
//   result : temperature in 0.01 degC, fine temperature, pressure in Pa as
//            unsigned Q24.8, and a flag set when the pressure divisor was
//            zero (pressure then reads 0).
//   cfg    : register writes, index 0 temperature coefficients, 1 and 2
//            pressure coefficients one to eight, 3 the ninth coefficient.
//            Other indexes are ignored. Write only while no item is in flight.
// Timing:
//   One item per cycle while the receiver is not stalling. An item passes
//   11 front stages, a 64-stage divider (one quotient bit per stage) and
//   6 back stages ending in the output register.
// Reset clears all valid bits and the coefficient registers.
// When the receiver stalls, the whole pipeline holds and sample.ready drops
// in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_unit (
  input  logic   clk,
  input  logic   rst,
  ptc_in_if.sink  sample,
  ptc_out_if.source result,
  ptc_cfg_if.sink cfg
);
  import ptc_pkg::*;

  localparam int FRONT_N = 11;
  localparam int BACK_N  = 6;

  // coefficient registers
  logic [47:0]        temp_coeffs;
  logic [63:0]        press_lo;
  logic [63:0]        press_hi;
  logic [15:0]        press_nine;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_lo    <= '0;
      press_hi    <= '0;
      press_nine  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TEMP:  temp_coeffs <= cfg.data[47:0];
        REG_PLOW:  press_lo    <= cfg.data;
        REG_PHIGH: press_hi    <= cfg.data;
        REG_PNINE: press_nine  <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = press_lo[15:0];
  assign p2 = press_lo[31:16];
  assign p3 = press_lo[47:32];
  assign p4 = press_lo[63:48];
  assign p5 = press_hi[15:0];
  assign p6 = press_hi[31:16];
  assign p7 = press_hi[47:32];
  assign p8 = press_hi[63:48];
  assign p9 = press_nine;

  // global advance
  logic en;
  logic out_vld;
  assign en           = ~out_vld | result.ready;
  assign sample.ready = en;

  logic [FRONT_N-1:0] vld_f;
  logic [BACK_N-1:0]  vld_b;
  logic               div_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= '0;
      vld_b <= '0;
    end else if (en) begin
      vld_f <= {vld_f[FRONT_N-2:0], sample.valid};
      vld_b <= {vld_b[BACK_N-2:0], div_vld};
    end
  end
  assign out_vld = vld_b[BACK_N-1];

  // ---------------- temperature path ----------------
  logic [31:0]        s1_ta, s1_tb, s2_ta2, s2_tbb, tbb_sh;
  logic [19:0]        s1_adcp, s2_adcp, s3_adcp, s4_adcp, s5_adcp, s6_adcp, s7_adcp, s8_adcp;
  logic signed [31:0] s3_a, s3_b1, s4_fine, fine5;
  tag_t               s5_tag, s6_tag, s7_tag, s8_tag, s9_tag, s10_tag, s11_tag;
  logic signed [33:0] s5_v1;

  assign tbb_sh = $unsigned($signed(s2_tbb) >>> 12);
  assign fine5  = s4_fine + (s4_fine <<< 2) + 32'sd128;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta   <= {15'd0, sample.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
      s1_tb   <= {16'd0, sample.raw_temperature[19:4]} - {16'd0, t1};
      s1_adcp <= sample.raw_pressure;

      s2_ta2  <= s1_ta * {{16{t2[15]}}, t2};
      s2_tbb  <= s1_tb * s1_tb;
      s2_adcp <= s1_adcp;

      s3_a    <= $signed(s2_ta2) >>> 11;
      s3_b1   <= $signed(tbb_sh * {{16{t3[15]}}, t3});
      s3_adcp <= s2_adcp;

      s4_fine <= s3_a + (s3_b1 >>> 14);
      s4_adcp <= s3_adcp;

      s5_tag.temp <= fine5 >>> 8;
      s5_tag.fine <= s4_fine;
      s5_tag.dz   <= 1'b0;
      s5_tag.neg  <= 1'b0;
      s5_v1       <= $signed({{2{s4_fine[31]}}, s4_fine}) - T_OFFSET;
      s5_adcp     <= s4_adcp;
    end
  end

  // ---------------- pressure path, divisor and dividend ----------------
  logic signed [67:0] sq_full;
  logic signed [63:0] m5_w, m2_w, x6_w, x3_w, p4_w;
  logic signed [63:0] s6_sq, s6_m5, s6_m2, s7_x6, s7_x3, s7_m5, s7_m2, s8_v2, s8_v1;
  logic [63:0]        s9_y, s9_n, s10_num, s11_num;
  logic [20:0]        pdiff;
  logic signed [30:0] s10_dv;
  logic [30:0]        s11_dvs;

  assign sq_full = 68'(s5_v1) * 68'(s5_v1);
  assign m5_w    = 64'(s5_v1) * 64'(p5);
  assign m2_w    = 64'(s5_v1) * 64'(p2);
  assign x6_w    = s6_sq * 64'(p6);
  assign x3_w    = s6_sq * 64'(p3);
  assign p4_w    = {{48{p4[15]}}, p4};
  assign pdiff   = P_FULL - {1'b0, s8_adcp};

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sq   <= sq_full[63:0];
      s6_m5   <= m5_w;
      s6_m2   <= m2_w;
      s6_tag  <= s5_tag;
      s6_adcp <= s5_adcp;

      s7_x6   <= x6_w;
      s7_x3   <= x3_w;
      s7_m5   <= s6_m5;
      s7_m2   <= s6_m2;
      s7_tag  <= s6_tag;
      s7_adcp <= s6_adcp;

      s8_v2   <= s7_x6 + (s7_m5 <<< 17) + (p4_w <<< 35);
      s8_v1   <= (s7_x3 >>> 8) + (s7_m2 <<< 12);
      s8_tag  <= s7_tag;
      s8_adcp <= s7_adcp;

      s9_y    <= (BIAS47 + $unsigned(s8_v1)) * {48'd0, p1};
      s9_n    <= {12'd0, pdiff, 31'd0} - $unsigned(s8_v2);
      s9_tag  <= s8_tag;

      s10_dv  <= $signed(s9_y[63:33]);
      s10_num <= s9_n * 64'(P_SCALE);
      s10_tag <= {s9_tag.temp, s9_tag.fine, (s9_y[63:33] == '0), s9_tag.neg};

      // take magnitudes, remember the quotient sign
      s11_num <= s10_num[63] ? (64'd0 - s10_num) : s10_num;
      s11_dvs <= s10_dv[30] ? $unsigned(31'sd0 - s10_dv) : $unsigned(s10_dv);
      s11_tag <= {s10_tag.temp, s10_tag.fine, s10_tag.dz, s10_num[63] ^ s10_dv[30]};
    end
  end

  // ---------------- divider ----------------
  logic [63:0] div_quo;
  tag_t        div_tag;

  ptc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (vld_f[FRONT_N-1]),
    .num     (s11_num),
    .dvs     (s11_dvs),
    .in_tag  (s11_tag),
    .out_vld (div_vld),
    .quo     (div_quo),
    .out_tag (div_tag)
  );

  // ---------------- correction terms and saturation ----------------
  logic signed [63:0] b0_q, b1_q, b2_q, b3_q, b1_w2, b2_w2, b3_w2, b3_z, b4_sum;
  logic signed [63:0] q_sh, z_w, w2_w, fin_w, p7_w;
  logic [63:0]        b1_pp0, b2_sq;
  logic [31:0]        b1_pp1;
  tag_t               b0_tag, b1_tag, b2_tag, b3_tag, b4_tag;

  logic signed [31:0] out_temp, out_fine;
  logic [31:0]        out_press;
  logic               out_dz;

  assign q_sh  = b0_q >>> 13;
  assign w2_w  = b0_q * 64'(p8);
  assign z_w   = $signed(b2_sq) * 64'(p9);
  assign p7_w  = {{48{p7[15]}}, p7};
  assign fin_w = (b4_sum >>> 8) + (p7_w <<< 4);

  always_ff @(posedge clk) begin
    if (en) begin
      b0_q   <= div_tag.neg ? $signed(64'd0 - div_quo) : $signed(div_quo);
      b0_tag <= div_tag;

      // square of q>>13 modulo 2^64 from 32-bit partial products
      b1_pp0 <= {32'd0, q_sh[31:0]} * {32'd0, q_sh[31:0]};
      b1_pp1 <= q_sh[31:0] * q_sh[63:32];
      b1_w2  <= w2_w;
      b1_q   <= b0_q;
      b1_tag <= b0_tag;

      b2_sq  <= b1_pp0 + {b1_pp1[30:0], 33'd0};
      b2_w2  <= b1_w2;
      b2_q   <= b1_q;
      b2_tag <= b1_tag;

      b3_z   <= z_w;
      b3_w2  <= b2_w2;
      b3_q   <= b2_q;
      b3_tag <= b2_tag;

      b4_sum <= b3_q + (b3_z >>> 25) + (b3_w2 >>> 19);
      b4_tag <= b3_tag;

      out_temp <= b4_tag.temp;
      out_fine <= b4_tag.fine;
      out_dz   <= b4_tag.dz;
      if (b4_tag.dz || fin_w[63]) begin
        out_press <= '0;
      end else if (|fin_w[63:32]) begin
        out_press <= '1;
      end else begin
        out_press <= fin_w[31:0];
      end
    end
  end

  assign result.valid             = out_vld;
  assign result.temperature_centi = out_temp;
  assign result.fine_temperature  = out_fine;
  assign result.pressure_q24_8    = out_press;
  assign result.divide_by_zero    = out_dz;

endmodule

[rtl/ptc_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_chk
// Port-level checks of the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_press,
  input logic        out_dz
);

  // input side stalls exactly when a result waits
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("sample.ready does not track result stall");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_dz_zero_press: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dz) |-> (out_press == 32'd0))
    else $error("pressure not zero on divide by zero");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_press) && $stable(out_dz)))
    else $error("stalled result changed");

endmodule

bind pressure_temperature_compensation_unit ptc_chk u_ptc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_press (result.pressure_q24_8),
  .out_dz    (result.divide_by_zero)
);
